### rtl/epd_pkg.sv
// Shared constants, types and helper functions of the ellipse point and derivative evaluator.
// No dependencies; used by every module in rtl/.
package epd_pkg;

	// default number of CORDIC cells
	localparam int CORDIC_STAGES_DEF = 18;

	// CORDIC datapath width (Q30 with headroom)
	localparam int CW = 34;

	// angle constants in Q30
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [CW-1:0] ONE_Q30   = 34'sd1073741824;

	// reciprocal of two pi, scaled by 2^30; estimate quotient = (angle * RECIP) >> 46
	localparam logic [63:0] RECIP_FULL = 64'd1152921504606846976 / 64'd6746518852;
	localparam logic [28:0] RECIP = RECIP_FULL[28:0];

	// reciprocal of the squared gain after each stage that still changes it (Q30)
	localparam logic [63:0] K2_0  = 64'd1 << 30;
	localparam logic [63:0] K2_1  = (K2_0  << 30) / ((64'd1 << 30) + (64'd1 << 30));
	localparam logic [63:0] K2_2  = (K2_1  << 30) / ((64'd1 << 30) + (64'd1 << 28));
	localparam logic [63:0] K2_3  = (K2_2  << 30) / ((64'd1 << 30) + (64'd1 << 26));
	localparam logic [63:0] K2_4  = (K2_3  << 30) / ((64'd1 << 30) + (64'd1 << 24));
	localparam logic [63:0] K2_5  = (K2_4  << 30) / ((64'd1 << 30) + (64'd1 << 22));
	localparam logic [63:0] K2_6  = (K2_5  << 30) / ((64'd1 << 30) + (64'd1 << 20));
	localparam logic [63:0] K2_7  = (K2_6  << 30) / ((64'd1 << 30) + (64'd1 << 18));
	localparam logic [63:0] K2_8  = (K2_7  << 30) / ((64'd1 << 30) + (64'd1 << 16));
	localparam logic [63:0] K2_9  = (K2_8  << 30) / ((64'd1 << 30) + (64'd1 << 14));
	localparam logic [63:0] K2_10 = (K2_9  << 30) / ((64'd1 << 30) + (64'd1 << 12));
	localparam logic [63:0] K2_11 = (K2_10 << 30) / ((64'd1 << 30) + (64'd1 << 10));
	localparam logic [63:0] K2_12 = (K2_11 << 30) / ((64'd1 << 30) + (64'd1 << 8));
	localparam logic [63:0] K2_13 = (K2_12 << 30) / ((64'd1 << 30) + (64'd1 << 6));
	localparam logic [63:0] K2_14 = (K2_13 << 30) / ((64'd1 << 30) + (64'd1 << 4));
	localparam logic [63:0] K2_15 = (K2_14 << 30) / ((64'd1 << 30) + (64'd1 << 2));
	localparam logic [63:0] K2_16 = (K2_15 << 30) / ((64'd1 << 30) + (64'd1 << 0));

	// one CORDIC vector travelling down the row of cells
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 neg;
	} cordic_t;

	// integer square root, digit by digit
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_w;
		logic [63:0] rem;
		res = '0;
		rem = v;
		bit_w = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (bit_w > rem) bit_w = bit_w >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (bit_w != 0) begin
				if (rem >= res + bit_w) begin
					rem = rem - (res + bit_w);
					res = (res >> 1) + bit_w;
				end else begin
					res = res >> 1;
				end
				bit_w = bit_w >> 2;
			end
		end
		return res;
	endfunction

	// start value of x: reciprocal of the CORDIC gain in Q30 for n cells, n of 8 or more
	function automatic logic [CW-1:0] gain_q30(input int n);
		logic [63:0] k2;
		logic [63:0] g;
		case (n)
			8:       k2 = K2_8;
			9:       k2 = K2_9;
			10:      k2 = K2_10;
			11:      k2 = K2_11;
			12:      k2 = K2_12;
			13:      k2 = K2_13;
			14:      k2 = K2_14;
			15:      k2 = K2_15;
			default: k2 = K2_16;
		endcase
		g = isqrt64(k2 << 30);
		return g[CW-1:0];
	endfunction

	// micro-rotation angle atan(2^-i) in Q30
	function automatic logic [CW-1:0] atan_q30(input int i);
		logic [CW-1:0] a;
		case (i)
			0:       a = 34'd843314857;
			1:       a = 34'd497837829;
			2:       a = 34'd263043837;
			3:       a = 34'd133525159;
			4:       a = 34'd67021687;
			5:       a = 34'd33543516;
			6:       a = 34'd16775851;
			7:       a = 34'd8388437;
			8:       a = 34'd4194283;
			9:       a = 34'd2097149;
			default: a = (i <= 30) ? (34'd1 << (30 - i)) : '0;
		endcase
		return a;
	endfunction

	// saturate to signed 32 bits
	function automatic logic [31:0] sat32(input logic signed [36:0] v);
		logic [31:0] r;
		if (v > 37'sd2147483647)       r = 32'h7FFF_FFFF;
		else if (v < -37'sd2147483648) r = 32'h8000_0000;
		else                           r = v[31:0];
		return r;
	endfunction

endpackage

### rtl/ellipse_point_derivative_eval_core.sv
// Top level of the ellipse point and derivative evaluator.
// Depends on epd_pkg, epd_reduce, epd_cordic_cell, epd_combine.
//
// Input channel: angle (signed Q16.16 radians) with in_valid/in_stall; a transfer
// happens on a clock edge with in_valid high and in_stall low.
// Output channel: point, first, second and third derivative (x, y, z, Q16.16,
// saturated) with out_valid/out_stall; one result per accepted angle, in order.
// Configuration: cfg_wr_en, cfg_index, cfg_data write the axis and centre
// registers; write only while no item is in flight. Unknown indexes are ignored.
// Pipeline: 5 reduction stages + CORDIC_STAGES cells + 4 combine stages.
// Throughput: one angle per cycle while out_stall is low; every stage is a register with its own valid
// bit, so bubbles close up and a new angle is taken while a result waits.
// Out stall: back-pressure ripples stage by stage; in_stall rises only once the
// whole row is full.
// Reset: clears all valid bits and loads the axis registers with the unit
// ellipse (A = x axis, B = y axis, centre at the origin).
module ellipse_point_derivative_eval_core #(
	parameter int CORDIC_STAGES = epd_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic signed [31:0] first_x,
	output logic signed [31:0] first_y,
	output logic signed [31:0] first_z,
	output logic signed [31:0] second_x,
	output logic signed [31:0] second_y,
	output logic signed [31:0] second_z,
	output logic signed [31:0] third_x,
	output logic signed [31:0] third_y,
	output logic signed [31:0] third_z,
	input  logic               cfg_wr_en,
	input  logic [3:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	typedef enum logic [3:0] {
		REG_MAJOR_X  = 4'd0,
		REG_MAJOR_Y  = 4'd1,
		REG_MAJOR_Z  = 4'd2,
		REG_MINOR_X  = 4'd3,
		REG_MINOR_Y  = 4'd4,
		REG_MINOR_Z  = 4'd5,
		REG_CENTER_XY = 4'd6,
		REG_CENTER_Z = 4'd7
	} reg_idx_t;

	logic signed [31:0] ax_q [3];
	logic signed [31:0] bx_q [3];
	logic signed [31:0] cx_q [3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q[0] <= 32'sd65536;
			ax_q[1] <= '0;
			ax_q[2] <= '0;
			bx_q[0] <= '0;
			bx_q[1] <= 32'sd65536;
			bx_q[2] <= '0;
			cx_q[0] <= '0;
			cx_q[1] <= '0;
			cx_q[2] <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_MAJOR_X:   ax_q[0] <= cfg_data[31:0];
				REG_MAJOR_Y:   ax_q[1] <= cfg_data[31:0];
				REG_MAJOR_Z:   ax_q[2] <= cfg_data[31:0];
				REG_MINOR_X:   bx_q[0] <= cfg_data[31:0];
				REG_MINOR_Y:   bx_q[1] <= cfg_data[31:0];
				REG_MINOR_Z:   bx_q[2] <= cfg_data[31:0];
				REG_CENTER_XY: begin
					cx_q[0] <= cfg_data[31:0];
					cx_q[1] <= cfg_data[63:32];
				end
				REG_CENTER_Z:  cx_q[2] <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic in_ready;
	logic red_valid, red_ready;
	epd_pkg::cordic_t red_data;

	logic             cv [CORDIC_STAGES+1];
	logic             cr [CORDIC_STAGES+1];
	epd_pkg::cordic_t cd [CORDIC_STAGES+1];

	assign in_stall = !in_ready;

	// angle reduction
	epd_reduce #(.CORDIC_STAGES(CORDIC_STAGES)) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.out_valid (red_valid),
		.out_ready (red_ready),
		.out_data  (red_data)
	);

	assign cv[0] = red_valid;
	assign cd[0] = red_data;
	assign red_ready = cr[0];

	// row of CORDIC cells
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		epd_cordic_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (cr[i]),
			.in_data   (cd[i]),
			.out_valid (cv[i+1]),
			.out_ready (cr[i+1]),
			.out_data  (cd[i+1])
		);
	end

	logic [31:0] pt_w [3], d1_w [3], d2_w [3], d3_w [3];

	// products, rounding and output register
	epd_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv[CORDIC_STAGES]),
		.in_ready  (cr[CORDIC_STAGES]),
		.in_data   (cd[CORDIC_STAGES]),
		.ax        (ax_q),
		.bx        (bx_q),
		.cx        (cx_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pt        (pt_w),
		.d1        (d1_w),
		.d2        (d2_w),
		.d3        (d3_w)
	);

	assign point_x  = pt_w[0];
	assign point_y  = pt_w[1];
	assign point_z  = pt_w[2];
	assign first_x  = d1_w[0];
	assign first_y  = d1_w[1];
	assign first_z  = d1_w[2];
	assign second_x = d2_w[0];
	assign second_y = d2_w[1];
	assign second_z = d2_w[2];
	assign third_x  = d3_w[0];
	assign third_y  = d3_w[1];
	assign third_z  = d3_w[2];

endmodule

### rtl/epd_reduce.sv
// Angle reduction pipeline: Q16.16 angle to a Q30 CORDIC start vector in [-pi/2, pi/2].
// Depends on epd_pkg.
module epd_reduce #(
	parameter int CORDIC_STAGES = epd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [31:0]    angle,
	output logic                  out_valid,
	input  logic                  out_ready,
	output epd_pkg::cordic_t      out_data
);

	localparam logic [epd_pkg::CW-1:0] GAIN = epd_pkg::gain_q30(CORDIC_STAGES);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic signed [31:0] a_s1, a_s2;
	logic signed [13:0] q_s2;
	logic signed [35:0] rem_s3, r_s4;
	logic signed [epd_pkg::CW-1:0] z_s5;
	logic neg_s5;

	logic signed [61:0] prod_w;
	logic signed [47:0] r48_w;
	logic signed [49:0] qt_w;
	logic signed [47:0] rem48_w;
	logic signed [35:0] fix_w;
	logic signed [35:0] t_w;
	logic neg_w;

	// ready ripples back from the CORDIC row
	assign rdy5 = !vld_s5 || out_ready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// quotient estimate by reciprocal multiply
	assign prod_w = a_s1 * $signed({1'b0, epd_pkg::RECIP});

	// remainder against the estimate, within one period either side
	assign r48_w   = {{2{a_s2[31]}}, a_s2, 14'b0};
	assign qt_w    = q_s2 * epd_pkg::TWO_PI_Q30;
	assign rem48_w = r48_w - qt_w[47:0];

	// correct into [0, 2pi)
	always_comb begin
		if (rem_s3 < 0)                           fix_w = rem_s3 + epd_pkg::TWO_PI_Q30;
		else if (rem_s3 >= epd_pkg::TWO_PI_Q30)   fix_w = rem_s3 - epd_pkg::TWO_PI_Q30;
		else                                      fix_w = rem_s3;
	end

	// fold into [-pi/2, pi/2], remember the half-turn
	always_comb begin
		t_w = r_s4;
		neg_w = 1'b0;
		if (t_w > epd_pkg::PI_Q30) t_w = t_w - epd_pkg::TWO_PI_Q30;
		if (t_w > epd_pkg::HALF_PI_Q30) begin
			t_w = t_w - epd_pkg::PI_Q30;
			neg_w = 1'b1;
		end else if (t_w < -epd_pkg::HALF_PI_Q30) begin
			t_w = t_w + epd_pkg::PI_Q30;
			neg_w = 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy1) a_s1 <= angle;
		if (rdy2) begin
			a_s2 <= a_s1;
			q_s2 <= prod_w[59:46];
		end
		if (rdy3) rem_s3 <= rem48_w[35:0];
		if (rdy4) r_s4 <= fix_w;
		if (rdy5) begin
			z_s5 <= t_w[epd_pkg::CW-1:0];
			neg_s5 <= neg_w;
		end
	end

	assign out_valid = vld_s5;
	assign out_data.x = GAIN;
	assign out_data.y = '0;
	assign out_data.z = z_s5;
	assign out_data.neg = neg_s5;

	// corrected remainder lies within one period
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (r_s4 >= 0 && r_s4 < epd_pkg::TWO_PI_Q30))
		else $error("reduced angle outside one period");

	// estimate is never off by more than one period
	a_est_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (rem_s3 >= -epd_pkg::TWO_PI_Q30 && rem_s3 < 2 * epd_pkg::TWO_PI_Q30))
		else $error("quotient estimate off by more than one");

	// CORDIC input within the convergence range
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (z_s5 >= -epd_pkg::HALF_PI_Q30 && z_s5 <= epd_pkg::HALF_PI_Q30))
		else $error("CORDIC angle outside half-turn range");

endmodule

### rtl/epd_cordic_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation and its stage register.
// Depends on epd_pkg.
module epd_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  epd_pkg::cordic_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output epd_pkg::cordic_t out_data
);

	localparam logic signed [epd_pkg::CW-1:0] ATAN = epd_pkg::atan_q30(IDX);

	logic vld_q;
	epd_pkg::cordic_t data_q;
	epd_pkg::cordic_t nxt_w;
	logic signed [epd_pkg::CW-1:0] dx_w, dy_w;

	assign in_ready = !vld_q || out_ready;

	// micro-rotation toward zero residual angle
	assign dx_w = in_data.y >>> IDX;
	assign dy_w = in_data.x >>> IDX;
	always_comb begin
		nxt_w.neg = in_data.neg;
		if (in_data.z >= 0) begin
			nxt_w.x = in_data.x - dx_w;
			nxt_w.y = in_data.y + dy_w;
			nxt_w.z = in_data.z - ATAN;
		end else begin
			nxt_w.x = in_data.x + dx_w;
			nxt_w.y = in_data.y - dy_w;
			nxt_w.z = in_data.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (in_ready) vld_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready) data_q <= nxt_w;
	end

	assign out_valid = vld_q;
	assign out_data = data_q;

endmodule

### rtl/epd_combine.sv
// Combine pipeline: clamps sine/cosine, forms point and derivatives, output register.
// Depends on epd_pkg.
module epd_combine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  epd_pkg::cordic_t   in_data,
	input  logic signed [31:0] ax [3],
	input  logic signed [31:0] bx [3],
	input  logic signed [31:0] cx [3],
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        pt [3],
	output logic [31:0]        d1 [3],
	output logic [31:0]        d2 [3],
	output logic [31:0]        d3 [3]
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [31:0] c_s1, s_s1;
	logic signed [63:0] ca_s2 [3], sb_s2 [3], cb_s2 [3], sa_s2 [3];
	logic signed [34:0] off_s3 [3], d1_s3 [3];

	logic signed [epd_pkg::CW-1:0] cl_w, sl_w, cn_w, sn_w;
	logic signed [64:0] offsum_w [3], d1sum_w [3];

	assign rdy4 = !vld_s4 || !out_stall;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	// clamp to unit range, undo the half-turn
	always_comb begin
		if (in_data.x > epd_pkg::ONE_Q30)       cl_w = epd_pkg::ONE_Q30;
		else if (in_data.x < -epd_pkg::ONE_Q30) cl_w = -epd_pkg::ONE_Q30;
		else                                    cl_w = in_data.x;
		if (in_data.y > epd_pkg::ONE_Q30)       sl_w = epd_pkg::ONE_Q30;
		else if (in_data.y < -epd_pkg::ONE_Q30) sl_w = -epd_pkg::ONE_Q30;
		else                                    sl_w = in_data.y;
		cn_w = in_data.neg ? -cl_w : cl_w;
		sn_w = in_data.neg ? -sl_w : sl_w;
	end

	// exact sums of products, rounded half up to Q16.16
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			offsum_w[k] = {ca_s2[k][63], ca_s2[k]} + {sb_s2[k][63], sb_s2[k]}
				+ 65'sd536870912;
			d1sum_w[k]  = {cb_s2[k][63], cb_s2[k]} - {sa_s2[k][63], sa_s2[k]}
				+ 65'sd536870912;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			c_s1 <= cn_w[31:0];
			s_s1 <= sn_w[31:0];
		end
		for (int k = 0; k < 3; k++) begin
			if (rdy2) begin
				ca_s2[k] <= c_s1 * ax[k];
				sb_s2[k] <= s_s1 * bx[k];
				cb_s2[k] <= c_s1 * bx[k];
				sa_s2[k] <= s_s1 * ax[k];
			end
			if (rdy3) begin
				off_s3[k] <= offsum_w[k][64:30];
				d1_s3[k]  <= d1sum_w[k][64:30];
			end
			// output register
			if (rdy4) begin
				pt[k] <= epd_pkg::sat32(37'(cx[k]) + 37'(off_s3[k]));
				d1[k] <= epd_pkg::sat32(37'(d1_s3[k]));
				d2[k] <= epd_pkg::sat32(-37'(off_s3[k]));
				d3[k] <= epd_pkg::sat32(-37'(d1_s3[k]));
			end
		end
	end

	assign out_valid = vld_s4;

endmodule
